>>> rtl/core/acfc_pkg.sv
`timescale 1ns / 1ps

package acfc_pkg;

  // Ring geometry: averages are sum >> RingAw, so the depth stays a power of two.
  localparam int RingDepth = 32;
  localparam int RingAw    = $clog2(RingDepth);
  localparam int ValW      = 8;
  localparam int SumW      = ValW + RingAw;

  localparam int CfgW      = 7;
  localparam int CfgIdxW   = 3;
  localparam int NumFans   = 4;

  localparam int FifoDepth = 3;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Solar scale: floor(raw*100/2046)*2 == floor(raw*50/1023)*2
  localparam int SolarNum  = 50;
  localparam int SolarDen  = 1023;
  localparam int SolarMax  = 100;
  localparam int FahrOfs   = 32;
  localparam int DivFiveK  = 205;  // floor(y/5) == (y*205)>>10 for y < 1020

  typedef enum logic [CfgIdxW-1:0] {
    CfgTempSp   = 3'd0,
    CfgHumSp    = 3'd1,
    CfgSolarThr = 3'd2,
    CfgFanOne   = 3'd3,
    CfgFanTwo   = 3'd4,
    CfgFanThree = 3'd5,
    CfgFanFour  = 3'd6,
    CfgPower    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FanOff  = 2'd0,
    FanOn   = 2'd1,
    FanAuto = 2'd2
  } fan_mode_e;

  typedef enum logic [1:0] {
    PwrOff    = 2'd0,
    PwrNormal = 2'd1,
    PwrSolar  = 2'd2
  } power_mode_e;

  // One ring request, issued in the accept cycle.
  typedef struct packed {
    logic            fill;
    logic            push;
    logic [ValW-1:0] value;
  } ring_req_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [6:0] average_solar;
    logic [6:0] humidity_now;
    logic [7:0] average_temperature_f;
    logic [3:0] fan_drive;
  } result_t;

  localparam int ResultW = $bits(result_t);
  localparam int OutDataW = ((ResultW + 7) / 8) * 8;

  function automatic logic [ValW-1:0] to_fahrenheit(input logic [5:0] c);
    logic [9:0]  y;
    logic [17:0] p;
    y = ({4'b0, c} << 3) + {4'b0, c};
    p = 18'(y) * 18'(DivFiveK);
    return p[17:10] + ValW'(FahrOfs);
  endfunction

  function automatic logic [6:0] solar_scale(input logic [9:0] raw);
    logic [15:0] x;
    logic [5:0]  qe;
    logic [15:0] r;
    logic [5:0]  q;
    x  = 16'(raw) * 16'(SolarNum);
    qe = x[15:10];
    r  = x - {qe, 10'b0} + 16'(qe);
    q  = qe + 6'(r >= 16'(SolarDen));
    return {q, 1'b0};
  endfunction

endpackage

>>> rtl/core/averaged_climate_fan_controller_unit.sv
`timescale 1ns / 1ps

// Averaged climate fan controller.
// Input stream: one request per reading. tuser = operation (0 climate,
// 1 solar); tdata carries temperature_c, humidity_pct and solar_raw.
// Each request yields exactly one result on the output stream: fan drive
// bits, averaged Fahrenheit, held humidity and averaged solar level.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i;
// write only while no request is in flight.
// Stage 2 pushes each result into the output queue. Throughput: one request
// per cycle while s_axis_tready is high. Each reading does one read of its
// ring memory (slot ahead of the current one) in the accept cycle and the
// sum update plus write-back in the next; distinct slots, so no hazard.
// Reset: sums, slots and flags clear at once, no memory sweep. The first
// reading of each kind primes its ring by value; untouched slots read as
// that value until the slot pointer has gone once around.
// Stall: results sit in a three-entry queue; s_axis_tready stays high while
// queue plus in-flight requests stay under three, so a stalled receiver
// backs up into tready without losing or repeating results.
module averaged_climate_fan_controller_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] temperature_c, [12:6] humidity_pct, [22:13] solar_raw, [23] zero
  input  logic [23:0]                       s_axis_tdata,
  // [0] operation
  input  logic                              s_axis_tuser,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] fan_drive, [11:4] average_temperature_f, [18:12] humidity_now,
  // [25:19] average_solar, [31:26] zero
  output logic [acfc_pkg::OutDataW-1:0]     m_axis_tdata,

  input  logic                              cfg_we_i,
  input  logic [acfc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [acfc_pkg::CfgW-1:0]         cfg_data_i
);

  // Config registers
  logic [6:0] temp_sp_q, hum_sp_q, solar_thr_q;
  logic [1:0] fan_mode_q [acfc_pkg::NumFans];
  logic [1:0] power_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_sp_q    <= 7'd78;
      hum_sp_q     <= 7'd85;
      solar_thr_q  <= 7'd30;
      for (int i = 0; i < acfc_pkg::NumFans; i++) begin
        fan_mode_q[i] <= acfc_pkg::FanAuto;
      end
      power_mode_q <= acfc_pkg::PwrNormal;
    end else if (cfg_we_i) begin
      case (acfc_pkg::cfg_idx_e'(cfg_idx_i))
        acfc_pkg::CfgTempSp:   temp_sp_q     <= cfg_data_i;
        acfc_pkg::CfgHumSp:    hum_sp_q      <= cfg_data_i;
        acfc_pkg::CfgSolarThr: solar_thr_q   <= cfg_data_i;
        acfc_pkg::CfgFanOne:   fan_mode_q[0] <= cfg_data_i[1:0];
        acfc_pkg::CfgFanTwo:   fan_mode_q[1] <= cfg_data_i[1:0];
        acfc_pkg::CfgFanThree: fan_mode_q[2] <= cfg_data_i[1:0];
        acfc_pkg::CfgFanFour:  fan_mode_q[3] <= cfg_data_i[1:0];
        acfc_pkg::CfgPower:    power_mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: accept, convert, issue ring requests
  logic       accept;
  logic       op_solar;
  logic [5:0] celsius;
  logic [6:0] humidity;
  logic [9:0] solar_raw;

  logic       climate_primed_q, solar_primed_q;
  logic [5:0] last_celsius_q;
  logic [6:0] held_hum_q;
  logic       s2_valid_q;

  acfc_pkg::ring_req_t t_req, s_req;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign op_solar  = s_axis_tuser;
  assign celsius   = s_axis_tdata[5:0];
  assign humidity  = s_axis_tdata[12:6];
  assign solar_raw = s_axis_tdata[22:13];

  always_comb begin
    t_req.fill  = accept && !op_solar && !climate_primed_q;
    t_req.push  = accept && !op_solar && climate_primed_q && (celsius != last_celsius_q);
    t_req.value = acfc_pkg::to_fahrenheit(celsius);
    s_req.fill  = accept && op_solar && !solar_primed_q;
    s_req.push  = accept && op_solar && solar_primed_q;
    s_req.value = {1'b0, acfc_pkg::solar_scale(solar_raw)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      climate_primed_q <= 1'b0;
      solar_primed_q   <= 1'b0;
      last_celsius_q   <= '0;
      held_hum_q       <= '0;
      s2_valid_q       <= 1'b0;
    end else begin
      s2_valid_q <= accept;
      if (accept && !op_solar) begin
        climate_primed_q <= 1'b1;
        last_celsius_q   <= celsius;
        held_hum_q       <= humidity;
      end
      if (accept && op_solar) begin
        solar_primed_q <= 1'b1;
      end
    end
  end

  logic [acfc_pkg::SumW-1:0] t_sum_next, s_sum_next;

  acfc_ring u_temp_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (t_req),
    .sum_next_o (t_sum_next)
  );

  acfc_ring u_solar_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (s_req),
    .sum_next_o (s_sum_next)
  );

  // Stage 2: averages and fan decision from the updated sums
  logic [7:0]        avg_t;
  logic [6:0]        avg_s;
  logic              hot, gated;
  acfc_pkg::result_t result;

  assign avg_t = t_sum_next[acfc_pkg::RingAw +: 8];
  assign avg_s = s_sum_next[acfc_pkg::RingAw +: 7];

  always_comb begin
    gated = (power_mode_q == acfc_pkg::PwrOff) ||
            ((power_mode_q == acfc_pkg::PwrSolar) && (avg_s < solar_thr_q));
    hot   = (avg_t >= {1'b0, temp_sp_q}) || (held_hum_q >= hum_sp_q);
    result.fan_drive = '0;
    for (int i = 0; i < acfc_pkg::NumFans; i++) begin
      result.fan_drive[i] = !gated &&
                            ((fan_mode_q[i] == acfc_pkg::FanOn) ||
                             ((fan_mode_q[i] == acfc_pkg::FanAuto) && hot));
    end
    result.average_temperature_f = avg_t;
    result.humidity_now          = held_hum_q;
    result.average_solar         = avg_s;
  end

  // Output queue with credit-based back-pressure
  logic [acfc_pkg::FifoCntW-1:0] q_count;
  acfc_pkg::result_t             q_data;
  logic [acfc_pkg::FifoCntW:0]   in_flight;

  acfc_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .data_i  (result),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  assign in_flight     = {1'b0, q_count} + (acfc_pkg::FifoCntW + 1)'(s2_valid_q);
  assign s_axis_tready = in_flight < (acfc_pkg::FifoCntW + 1)'(acfc_pkg::FifoDepth);
  assign m_axis_tdata  = {(acfc_pkg::OutDataW - acfc_pkg::ResultW)'(0), q_data};

endmodule

>>> rtl/core/acfc_ram.sv
`timescale 1ns / 1ps

module acfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/core/acfc_ring.sv
`timescale 1ns / 1ps

// Ring of samples plus running sum. Fill is lazy: entries not yet rewritten
// since the fill read as fill_val_q; lap_q marks that every slot was rewritten.
module acfc_ring (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  acfc_pkg::ring_req_t             req_i,
  output logic [acfc_pkg::SumW-1:0]       sum_next_o
);

  logic [acfc_pkg::RingAw-1:0] slot_q, slot_inc;
  logic                        lap_q;
  logic [acfc_pkg::ValW-1:0]   fill_val_q;
  logic [acfc_pkg::SumW-1:0]   sum_q, sum_d;

  logic                        s2_fill_q, s2_push_q;
  logic                        s2_old_valid_q;
  logic [acfc_pkg::ValW-1:0]   s2_val_q;
  logic [acfc_pkg::RingAw-1:0] s2_addr_q;

  logic [acfc_pkg::ValW-1:0]   rdata, old_val;

  assign slot_inc = (slot_q == acfc_pkg::RingAw'(acfc_pkg::RingDepth - 1))
                    ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      lap_q     <= 1'b0;
      s2_fill_q <= 1'b0;
      s2_push_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      s2_fill_q <= req_i.fill;
      s2_push_q <= req_i.push;
      sum_q     <= sum_d;
      if (req_i.fill) begin
        slot_q <= '0;
        lap_q  <= 1'b0;
      end else if (req_i.push) begin
        slot_q <= slot_inc;
        if (slot_inc == '0) begin
          lap_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.fill) begin
      fill_val_q <= req_i.value;
    end
    s2_val_q       <= req_i.value;
    s2_addr_q      <= slot_inc;
    s2_old_valid_q <= lap_q;
  end

  acfc_ram #(
    .Width (acfc_pkg::ValW),
    .Depth (acfc_pkg::RingDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s2_push_q),
    .waddr_i (s2_addr_q),
    .wdata_i (s2_val_q),
    .raddr_i (slot_inc),
    .rdata_o (rdata)
  );

  assign old_val = s2_old_valid_q ? rdata : fill_val_q;

  always_comb begin
    sum_d = sum_q;
    if (s2_fill_q) begin
      sum_d = {s2_val_q, acfc_pkg::RingAw'(0)};
    end else if (s2_push_q) begin
      sum_d = sum_q - acfc_pkg::SumW'(old_val) + acfc_pkg::SumW'(s2_val_q);
    end
  end

  assign sum_next_o = sum_d;

endmodule

>>> rtl/core/acfc_ofifo.sv
`timescale 1ns / 1ps

// Small result queue; the producer holds back by credit (see count_o).
module acfc_ofifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  acfc_pkg::result_t               data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output acfc_pkg::result_t               data_o,
  output logic [acfc_pkg::FifoCntW-1:0]   count_o
);

  acfc_pkg::result_t                mem_q [acfc_pkg::FifoDepth];
  logic [acfc_pkg::FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [acfc_pkg::FifoCntW-1:0]    cnt_q;
  logic                             pop;

  function automatic logic [acfc_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [acfc_pkg::FifoPtrW-1:0] p
  );
    return (p == acfc_pkg::FifoPtrW'(acfc_pkg::FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/acfc_checker.sv
`timescale 1ns / 1ps

module acfc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [acfc_pkg::OutDataW-1:0] m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Every accepted request shows a valid result once through stage 2 and the queue.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ##1 m_axis_tvalid)
    else $error("result missing two cycles after request");

  // No result appears without a request behind it.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !in_acc && !$past(in_acc) |=> !m_axis_tvalid)
    else $error("result without request");

  // Solar average in range and padding clear.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[25:19] <= 7'(acfc_pkg::SolarMax)) &&
                      (m_axis_tdata[31:26] == '0))
    else $error("result field out of range");

endmodule

bind averaged_climate_fan_controller_unit acfc_checker u_acfc_checker (.*);

>>> test/averaged_climate_fan_controller_unit_test.sv
`timescale 1ns / 1ps

module averaged_climate_fan_controller_unit_test;
  import acfc_pkg::*;

  localparam int LatencySlack = 4;
  localparam int HoldCycles   = 60;      // long receiver hold-off
  localparam int CycleLimit   = 100000;
  localparam int PhaseCount   = 8;
  localparam int PhaseItems   = 62;
  localparam int ReportLimit  = 10;

  // Codes the package leaves unnamed: spare fan mode acts as off,
  // spare power mode acts as normal.
  localparam logic [1:0] FanSpare = 2'd3;
  localparam logic [1:0] PwrSpare = 2'd3;

  typedef struct {
    logic       op_solar;
    logic [5:0] celsius;
    logic [6:0] humidity;
    logic [9:0] raw;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;   // [5:0] celsius, [12:6] humidity, [22:13] raw
  logic                 s_axis_tuser;   // [0] operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [3:0] fan_drive, [11:4] avg Fahrenheit, [18:12] humidity, [25:19] avg solar
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_data_i;

  averaged_climate_fan_controller_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor state: rings, running sums, slot pointers and priming flags,
  // plus a shadow of every config register.
  // ---------------------------------------------------------------------
  logic [7:0]  temp_hist  [RingDepth];
  logic [6:0]  solar_hist [RingDepth];
  int unsigned temp_total    = 0;
  int unsigned solar_total   = 0;
  int unsigned temp_pos      = 0;
  int unsigned solar_pos     = 0;
  logic [5:0]  prev_celsius  = '0;
  logic [6:0]  humidity_held = '0;
  bit          climate_seen  = 1'b0;
  bit          solar_seen    = 1'b0;

  logic [6:0]  sp_temp   = 7'd78;
  logic [6:0]  sp_hum    = 7'd85;
  logic [6:0]  solar_min = 7'd30;
  logic [1:0]  fan_sel [NumFans] = '{FanAuto, FanAuto, FanAuto, FanAuto};
  logic [1:0]  power_sel = PwrNormal;

  result_t     pending_results [$];   // fan decisions still owed by the block
  result_t     seen_result;
  result_t     want_result;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          walk_celsius   = 25;   // random walk so repeats and small steps are common

  // Receiver controls, owned by the sink process below.
  bit sink_stalls = 1'b0;
  bit sink_hold   = 1'b0;

  // Advance the shadow state by one reading and return the result it owes.
  function automatic result_t predict_fan_result(input reading_t r);
    int unsigned fahr, level, avg_t, avg_s;
    logic        hot, gated;
    result_t     res;
    if (!r.op_solar) begin
      fahr = (r.celsius * 9) / 5 + 32;
      if (!climate_seen) begin
        // first climate reading primes the whole ring
        foreach (temp_hist[i]) temp_hist[i] = 8'(fahr);
        temp_total   = fahr * RingDepth;
        temp_pos     = 0;
        prev_celsius = r.celsius;
        climate_seen = 1'b1;
      end else if (r.celsius != prev_celsius) begin
        temp_pos            = (temp_pos + 1) % RingDepth;
        temp_total          = temp_total - temp_hist[temp_pos] + fahr;
        temp_hist[temp_pos] = 8'(fahr);
        prev_celsius        = r.celsius;
      end
      humidity_held = r.humidity;
    end else begin
      level = ((r.raw * 100) / 2046) * 2;
      if (!solar_seen) begin
        foreach (solar_hist[i]) solar_hist[i] = 7'(level);
        solar_total = level * RingDepth;
        solar_pos   = 0;
        solar_seen  = 1'b1;
      end else begin
        // solar pushes on every reading, changed or not
        solar_pos             = (solar_pos + 1) % RingDepth;
        solar_total           = solar_total - solar_hist[solar_pos] + level;
        solar_hist[solar_pos] = 7'(level);
      end
    end

    avg_t = temp_total / RingDepth;
    avg_s = solar_total / RingDepth;
    gated = (power_sel == PwrOff) || (power_sel == PwrSolar && avg_s < solar_min);
    hot   = (avg_t >= sp_temp) || (humidity_held >= sp_hum);

    res = '0;
    for (int i = 0; i < NumFans; i++) begin
      if (!gated && (fan_sel[i] == FanOn || (fan_sel[i] == FanAuto && hot)))
        res.fan_drive[i] = 1'b1;
    end
    res.average_temperature_f = 8'(avg_t);
    res.humidity_now          = humidity_held;
    res.average_solar         = 7'(avg_s);
    return res;
  endfunction

  function automatic void note_failure(input string what, input int unsigned want,
                                       input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
  endfunction

  // Level near a center, clipped to the 7-bit register range.
  function automatic logic [6:0] jitter_level(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 127) v = 127;
    return 7'(v);
  endfunction

  // Setpoints: half the time near the live value so comparisons flip, else an extreme.
  function automatic logic [6:0] setpoint_pick(input int center);
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd99;
      3:       return 7'd127;
      default: return jitter_level(center, 3);
    endcase
  endfunction

  function automatic reading_t climate_reading(input logic [5:0] c, input logic [6:0] h);
    reading_t r;
    r.op_solar = 1'b0;
    r.celsius  = c;
    r.humidity = h;
    r.raw      = 10'($urandom);   // unused field, random noise
    return r;
  endfunction

  function automatic reading_t solar_reading(input logic [9:0] raw);
    reading_t r;
    r.op_solar = 1'b1;
    r.celsius  = 6'($urandom);
    r.humidity = 7'($urandom);
    r.raw      = raw;
    return r;
  endfunction

  function automatic reading_t next_reading();
    reading_t r;
    int       c;
    r.op_solar = ($urandom_range(0, 4) < 2);
    case ($urandom_range(0, 2))
      0:       c = walk_celsius;
      1:       c = walk_celsius + int'($urandom_range(0, 6)) - 3;
      default: c = int'($urandom_range(0, 63));
    endcase
    if (c < 0) c = 0;
    if (c > 63) c = 63;
    walk_celsius = c;
    r.celsius  = 6'(c);
    r.humidity = ($urandom_range(0, 3) == 0) ? jitter_level(int'(sp_hum), 2)
                                             : 7'($urandom_range(0, 127));
    // bias toward dark or bright runs so the solar average drifts across the threshold
    case ($urandom_range(0, 2))
      0:       r.raw = 10'($urandom_range(0, 400));
      1:       r.raw = 10'($urandom_range(600, 1023));
      default: r.raw = 10'($urandom_range(0, 1023));
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side. Every task starts at a falling edge, so valid gets one
  // assignment per step: a back-to-back request just overwrites data.
  // ---------------------------------------------------------------------
  task automatic send_reading(input reading_t r);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op_solar;
    s_axis_tdata  <= {1'b0, r.raw, r.humidity, r.celsius};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_fan_result(r));
  endtask

  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop offering, wait for every owed result, then let the pipe empty.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LatencySlack) @(posedge clk_i);
  endtask

  // Only called while idle; the shadow register follows at the write edge.
  task automatic write_register(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgTempSp:   sp_temp   = value;
      CfgHumSp:    sp_hum    = value;
      CfgSolarThr: solar_min = value;
      CfgPower:    power_sel = value[1:0];
      default:     fan_sel[int'(idx) - int'(CfgFanOne)] = value[1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic shuffle_settings();
    logic [CfgW-1:0] pick;
    logic [1:0]      pwr;
    for (int i = int'(CfgTempSp); i <= int'(CfgPower); i++) begin
      case (cfg_idx_e'(i))
        CfgTempSp:   pick = setpoint_pick(temp_total / RingDepth);
        CfgHumSp:    pick = setpoint_pick(int'(humidity_held));
        CfgSolarThr: pick = setpoint_pick(solar_total / RingDepth);
        CfgPower: begin
          case ($urandom_range(0, 9))
            0:       pwr = PwrOff;
            1:       pwr = PwrSpare;
            2, 3, 4: pwr = PwrNormal;
            default: pwr = PwrSolar;
          endcase
          pick = {5'($urandom), pwr};   // upper bits are don't-care
        end
        default:     pick = 7'($urandom);   // fan mode in low bits, spare code included
      endcase
      write_register(cfg_idx_e'(i), pick);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Averages read zero before their first reading; first reading of each
  // kind primes the ring; same Celsius does not push; field extremes.
  task automatic test_first_readings();
    sink_stalls = 1'b0;
    send_reading(solar_reading(10'd1023));          // solar before any climate
    send_reading(climate_reading(6'd0, 7'd0));      // primes at 32 F
    send_reading(climate_reading(6'd0, 7'd100));    // unchanged Celsius
    send_reading(climate_reading(6'd63, 7'd127));   // top of both fields
    send_reading(climate_reading(6'd63, 7'd1));
    send_reading(climate_reading(6'd60, 7'd64));
    send_reading(solar_reading(10'd0));
    send_reading(solar_reading(10'd1022));
    send_reading(solar_reading(10'd1));
    send_reading(solar_reading(10'd512));
    settle();
  endtask

  // Every fan mode and power mode, setpoint and threshold extremes and the
  // exact at-setpoint boundaries.
  task automatic test_fan_settings();
    write_register(CfgFanOne, CfgW'(FanOff));
    write_register(CfgFanTwo, CfgW'(FanOn));
    write_register(CfgFanThree, CfgW'(FanAuto));
    write_register(CfgFanFour, CfgW'(FanSpare));
    write_register(CfgPower, CfgW'(PwrNormal));
    write_register(CfgTempSp, 7'd127);
    write_register(CfgHumSp, 7'd127);
    send_reading(climate_reading(6'd20, 7'd126));   // just below humidity setpoint
    send_reading(climate_reading(6'd20, 7'd127));   // humidity equal: hot
    settle();
    write_register(CfgTempSp, 7'(temp_total / RingDepth));  // temperature equal: hot
    send_reading(climate_reading(6'd20, 7'd0));
    settle();
    write_register(CfgTempSp, 7'd1);
    write_register(CfgHumSp, 7'd1);
    write_register(CfgPower, CfgW'(PwrOff));
    send_reading(climate_reading(6'd21, 7'd50));
    settle();
    write_register(CfgPower, CfgW'(PwrSpare));
    send_reading(solar_reading(10'd700));
    settle();
    write_register(CfgPower, CfgW'(PwrSolar));
    write_register(CfgSolarThr, 7'd127);            // always dark
    send_reading(solar_reading(10'd1023));
    settle();
    write_register(CfgSolarThr, 7'd0);              // never dark
    send_reading(solar_reading(10'd0));
    settle();
    write_register(CfgSolarThr, 7'(solar_total / RingDepth));  // level equal: runs
    send_reading(climate_reading(6'd22, 7'd90));
    settle();
    write_register(CfgSolarThr, 7'(solar_total / RingDepth + 1));  // one above: gated
    send_reading(climate_reading(6'd22, 7'd90));
    settle();
  endtask

  // Receiver holds off long enough for the result queue to fill and stall
  // the input while requests keep coming; then the sender waits it out.
  task automatic test_backpressure();
    write_register(CfgPower, CfgW'(PwrNormal));
    sink_stalls = 1'b0;
    sink_hold   = 1'b1;
    repeat (12) send_reading(next_reading());
    settle();
  endtask

  // Phases of random readings in bursts, each under new random settings,
  // with and without receiver stalls.
  task automatic test_random_stream();
    int burst;
    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      shuffle_settings();
      sink_stalls = (p % 3 != 0);
      burst = 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
        end
        send_reading(next_reading());
        burst--;
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: ready pattern of its own, or a long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin : sink_pattern
    int run;
    bit sink_on;
    run           = 0;
    sink_on       = 1'b1;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        sink_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (!sink_stalls) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (run == 0) begin
          sink_on = !sink_on;
          run     = sink_on ? $urandom_range(1, 10) : $urandom_range(1, 5);
        end else begin
          run--;
        end
        m_axis_tready <= sink_on;
      end
    end
  end

  // Result check: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result = result_t'(m_axis_tdata[ResultW-1:0]);
      if (pending_results.size() == 0) begin
        note_failure("result with nothing owed, data", 0, m_axis_tdata);
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result.fan_drive != want_result.fan_drive)
          note_failure("fan_drive", 32'(want_result.fan_drive),
                       32'(seen_result.fan_drive));
        if (seen_result.average_temperature_f != want_result.average_temperature_f)
          note_failure("average_temperature_f", 32'(want_result.average_temperature_f),
                       32'(seen_result.average_temperature_f));
        if (seen_result.humidity_now != want_result.humidity_now)
          note_failure("humidity_now", 32'(want_result.humidity_now),
                       32'(seen_result.humidity_now));
        if (seen_result.average_solar != want_result.average_solar)
          note_failure("average_solar", 32'(want_result.average_solar),
                       32'(seen_result.average_solar));
        if (m_axis_tdata[OutDataW-1:ResultW] != '0)
          note_failure("tdata padding", 0, 32'(m_axis_tdata[OutDataW-1:ResultW]));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgTempSp;
    cfg_data_i    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_first_readings();
    test_fan_settings();
    test_backpressure();
    test_random_stream();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
